>>> hw/rtl/hist_eq_pkg.sv
// Shared constants, codes, types and helpers for the histogram equalizer.
// No dependencies; used by hist_eq_div and histogram_equalizer.
package hist_eq_pkg;

    localparam int LEVELS   = 256;
    localparam int LVL_W    = $clog2(LEVELS);
    localparam int SWEEP_W  = LVL_W + 1;
    localparam int MAX_SIDE = 1024;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int AREA_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int CNT_W    = 21;
    localparam int OUT_W    = 8;
    localparam int STEP_W   = $clog2(OUT_W);
    localparam int DIV_W    = ((CNT_W > AREA_W) ? CNT_W : AREA_W) + OUT_W;
    localparam int ACT_W    = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // item actions
    localparam logic [ACT_W-1:0] ACT_COUNT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MAP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  sum;
        logic [SIDE_W-1:0] side_w;
        logic [SIDE_W-1:0] side_h;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] quot;
    } div_rsp_t;

    // zero acts as one, anything above MAX_SIDE acts as MAX_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [SIDE_W-1:0] s;
        if (v == '0)
        begin
            s = SIDE_W'(1);
        end
        else if (int'(v) > MAX_SIDE)
        begin
            s = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            s = SIDE_W'(v);
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/hist_eq_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No package dependencies.
module hist_eq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 21
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/hist_eq_div.sv
// Iterative divider: floor(sum * 255 / (side_w * side_h)), saturated to 255.
// Depends on hist_eq_pkg. One quotient bit per cycle after a saturation check.
module hist_eq_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hist_eq_pkg::div_req_t req,
    output hist_eq_pkg::div_rsp_t rsp
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_STEP
    } div_state_t;

    div_state_t                            state_reg;
    logic [hist_eq_pkg::AREA_W-1:0]        area_reg;
    logic [hist_eq_pkg::DIV_W-1:0]         rem_reg;
    logic [hist_eq_pkg::DIV_W-1:0]         dsr_reg;
    logic [hist_eq_pkg::OUT_W-1:0]         quot_reg;
    logic [hist_eq_pkg::STEP_W-1:0]        step_reg;
    logic                                  done_reg;

    logic [hist_eq_pkg::DIV_W-1:0]         dividend;
    logic [hist_eq_pkg::DIV_W-1:0]         full_dsr;
    logic [2*hist_eq_pkg::SIDE_W-1:0]      area_prod;
    logic                                  ge;

    // sum * 255 as (sum << 8) - sum
    assign dividend  = (hist_eq_pkg::DIV_W'(req.sum) << hist_eq_pkg::OUT_W)
                     - hist_eq_pkg::DIV_W'(req.sum);
    assign area_prod = req.side_w * req.side_h;
    assign full_dsr  = hist_eq_pkg::DIV_W'(area_reg) << hist_eq_pkg::OUT_W;
    assign ge        = (rem_reg >= dsr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            area_reg  <= '0;
            rem_reg   <= '0;
            dsr_reg   <= '0;
            quot_reg  <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        area_reg  <= hist_eq_pkg::AREA_W'(area_prod);
                        rem_reg   <= dividend;
                        state_reg <= D_CHECK;
                    end
                end
                D_CHECK:
                begin
                    // quotient of 256 or more saturates
                    if (rem_reg >= full_dsr)
                    begin
                        quot_reg  <= hist_eq_pkg::OUT_MAX;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        quot_reg  <= '0;
                        dsr_reg   <= hist_eq_pkg::DIV_W'(area_reg)
                                     << (hist_eq_pkg::OUT_W - 1);
                        step_reg  <= hist_eq_pkg::STEP_W'(hist_eq_pkg::OUT_W - 1);
                        state_reg <= D_STEP;
                    end
                end
                D_STEP:
                begin
                    if (ge)
                    begin
                        rem_reg <= rem_reg - dsr_reg;
                    end
                    quot_reg <= {quot_reg[hist_eq_pkg::OUT_W-2:0], ge};
                    dsr_reg  <= dsr_reg >> 1;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == D_IDLE)
        else $error("divider started while busy");

endmodule

>>> hw/rtl/histogram_equalizer.sv
// Histogram equalizer: a count writes the bin back from S_COUNT_WR; a clear
// acts at accept; a map word comes out after the table read and the divider
// (which ends early when the quotient saturates), after a rebuild of the
// running-sum table on the first map after any count or clear. Table read, then a 1-bit/cycle divider.
// One item in flight at a time; a finished word may wait in the output register.
// Reset (async, rst_n low) empties the histogram via per-bin valid flags,
// marks the sums stale and sets both frame dimensions to 1.
module histogram_equalizer (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [hist_eq_pkg::ACT_W-1:0]      action,
    input  logic [hist_eq_pkg::LVL_W-1:0]      pixel,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [hist_eq_pkg::OUT_W-1:0]      mapped_pixel,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hist_eq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hist_eq_pkg::CFG_W-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT_WR,
        S_BUILD,
        S_MAP_RD,
        S_MAP_LOAD,
        S_DIV,
        S_OUT
    } state_t;

    state_t                                state_reg;
    logic [hist_eq_pkg::LVL_W-1:0]         pix_reg;
    logic                                  sums_ready_reg;
    // a bin whose flag is clear reads as zero; clear drops all flags at once
    logic [hist_eq_pkg::LEVELS-1:0]        bin_valid_reg;
    logic                                  vq_reg;
    logic [hist_eq_pkg::SWEEP_W-1:0]       rd_idx_reg;
    logic                                  wr_pend_reg;
    logic [hist_eq_pkg::LVL_W-1:0]         wr_idx_reg;
    logic [hist_eq_pkg::CNT_W-1:0]         acc_reg;
    logic [hist_eq_pkg::OUT_W-1:0]         quot_reg;
    logic                                  result_valid_reg;
    logic [hist_eq_pkg::OUT_W-1:0]         mapped_pixel_reg;
    logic [hist_eq_pkg::CFG_W-1:0]         width_reg;
    logic [hist_eq_pkg::CFG_W-1:0]         height_reg;

    logic                                  item_acc;
    logic                                  out_free;

    logic                                  bin_we;
    logic [hist_eq_pkg::LVL_W-1:0]         bin_raddr;
    logic [hist_eq_pkg::CNT_W-1:0]         bin_rdata;
    logic [hist_eq_pkg::CNT_W-1:0]         bin_value;
    logic [hist_eq_pkg::CNT_W-1:0]         bin_inc;

    logic                                  sum_we;
    logic [hist_eq_pkg::CNT_W-1:0]         sum_rdata;
    logic [hist_eq_pkg::CNT_W:0]           acc_sum;
    logic [hist_eq_pkg::CNT_W-1:0]         acc_next;

    hist_eq_pkg::div_req_t                 div_req;
    hist_eq_pkg::div_rsp_t                 div_rsp;

    assign item_stall = (state_reg != S_IDLE);
    assign item_acc   = item_valid && (state_reg == S_IDLE);
    assign out_free   = !result_valid_reg || !result_stall;
    assign cfg_ready  = 1'b1;

    // Bin store: read at the incoming pixel when idle, at the sweep index
    // while rebuilding; written back in the cycle after a count is accepted.
    assign bin_raddr = (state_reg == S_BUILD) ? rd_idx_reg[hist_eq_pkg::LVL_W-1:0] : pixel;
    assign bin_value = vq_reg ? bin_rdata : '0;
    assign bin_inc   = (bin_value == hist_eq_pkg::CNT_MAX) ? bin_value : bin_value + 1'b1;
    assign bin_we    = (state_reg == S_COUNT_WR);

    // Running sum, saturating at the counter maximum
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, bin_value};
    assign acc_next = acc_sum[hist_eq_pkg::CNT_W] ? hist_eq_pkg::CNT_MAX
                                                  : acc_sum[hist_eq_pkg::CNT_W-1:0];
    assign sum_we   = (state_reg == S_BUILD) && wr_pend_reg;

    hist_eq_ram #(
        .DEPTH (hist_eq_pkg::LEVELS),
        .WIDTH (hist_eq_pkg::CNT_W)
    ) u_bins (
        .clk   (clk),
        .we    (bin_we),
        .waddr (pix_reg),
        .wdata (bin_inc),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    // Running-sum table, only read at the pixel of the map in progress
    hist_eq_ram #(
        .DEPTH (hist_eq_pkg::LEVELS),
        .WIDTH (hist_eq_pkg::CNT_W)
    ) u_sums (
        .clk   (clk),
        .we    (sum_we),
        .waddr (wr_idx_reg),
        .wdata (acc_next),
        .raddr (pix_reg),
        .rdata (sum_rdata)
    );

    assign div_req.start  = (state_reg == S_MAP_LOAD);
    assign div_req.sum    = sum_rdata;
    assign div_req.side_w = hist_eq_pkg::clamp_side(width_reg);
    assign div_req.side_h = hist_eq_pkg::clamp_side(height_reg);

    hist_eq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pix_reg          <= '0;
            sums_ready_reg   <= 1'b0;
            bin_valid_reg    <= '0;
            vq_reg           <= 1'b0;
            rd_idx_reg       <= '0;
            wr_pend_reg      <= 1'b0;
            wr_idx_reg       <= '0;
            acc_reg          <= '0;
            quot_reg         <= '0;
            result_valid_reg <= 1'b0;
            mapped_pixel_reg <= '0;
            width_reg        <= hist_eq_pkg::CFG_W'(1);
            height_reg       <= hist_eq_pkg::CFG_W'(1);
        end
        else
        begin
            // config writes must arrive only while idle; the block does not enforce this
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    hist_eq_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    hist_eq_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end

            // the output state reloads the register itself when it is drained
            if (result_valid_reg && !result_stall && (state_reg != S_OUT))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_acc)
                    begin
                        pix_reg <= pixel;
                        vq_reg  <= bin_valid_reg[pixel];
                        unique case (action)
                            hist_eq_pkg::ACT_COUNT:
                            begin
                                sums_ready_reg <= 1'b0;
                                state_reg      <= S_COUNT_WR;
                            end
                            hist_eq_pkg::ACT_MAP:
                            begin
                                rd_idx_reg  <= '0;
                                wr_pend_reg <= 1'b0;
                                acc_reg     <= '0;
                                state_reg   <= sums_ready_reg ? S_MAP_RD : S_BUILD;
                            end
                            hist_eq_pkg::ACT_CLEAR:
                            begin
                                bin_valid_reg  <= '0;
                                sums_ready_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_COUNT_WR:
                begin
                    bin_valid_reg[pix_reg] <= 1'b1;
                    state_reg              <= S_IDLE;
                end
                S_BUILD:
                begin
                    // read bin i while bin i-1 is summed and written
                    if (!rd_idx_reg[hist_eq_pkg::LVL_W])
                    begin
                        vq_reg      <= bin_valid_reg[rd_idx_reg[hist_eq_pkg::LVL_W-1:0]];
                        wr_idx_reg  <= rd_idx_reg[hist_eq_pkg::LVL_W-1:0];
                        wr_pend_reg <= 1'b1;
                        rd_idx_reg  <= rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        wr_pend_reg <= 1'b0;
                    end
                    if (wr_pend_reg)
                    begin
                        acc_reg <= acc_next;
                        if (wr_idx_reg == hist_eq_pkg::LVL_W'(hist_eq_pkg::LEVELS - 1))
                        begin
                            sums_ready_reg <= 1'b1;
                            state_reg      <= S_MAP_RD;
                        end
                    end
                end
                S_MAP_RD:
                begin
                    // sums table read at pix_reg lands next cycle
                    state_reg <= S_MAP_LOAD;
                end
                S_MAP_LOAD:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        quot_reg  <= div_rsp.quot;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        mapped_pixel_reg <= quot_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign mapped_pixel = mapped_pixel_reg;

    a_load_needs_sums: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAP_LOAD |-> sums_ready_reg)
        else $error("map table read before sums were built");

    a_sums_set_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sums_ready_reg) |-> $past(state_reg == S_BUILD))
        else $error("sums marked ready outside rebuild");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_OUT))
        else $error("result word raised outside output state");

endmodule
